### rtl/core/pffr_pkg.sv
package pffr_pkg;

  localparam int FRAMES      = 64;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int CNT_W       = FRAME_W + 1;
  localparam int ADDR_W      = 32;
  localparam int OFFSET_BITS = 12;
  localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
  localparam int STAMP_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int FC_W        = 7;

  localparam logic [STATUS_W-1:0] STAT_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FILL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EVICT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OOR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_END  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd5;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

### rtl/core/pffr_ctrl.sv
module pffr_ctrl
  import pffr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.in_range ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A request is taken only from idle and always leads to the range check.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted request did not enter range check");

  // The result is held back while the output register is still occupied.
  a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && !sts.out_free) |=> (state_r == S_COMMIT))
    else $error("commit left while output register was full");

  // A scan finishing outside the scan state means the datapath ran on its own.
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |-> (state_r == S_SCAN))
    else $error("scan completion outside scan state");

endmodule

### rtl/core/pffr_dp.sv
module pffr_dp
  import pffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     in_virtual_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_physical_address,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PAGE_W-1:0]     out_evicted_page,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts
);

  // Configuration registers.
  logic [ADDR_W-1:0] r0_base_r, r0_end_r, r1_base_r, r1_end_r;
  logic              policy_r;
  logic [FC_W-1:0]   frame_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_base_r     <= '0;
      r0_end_r      <= '0;
      r1_base_r     <= '0;
      r1_end_r      <= '0;
      policy_r      <= POLICY_FIFO;
      frame_count_r <= FC_W'(FRAMES);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE0_BASE: r0_base_r     <= cfg_data;
        REG_RANGE0_END:  r0_end_r      <= cfg_data;
        REG_RANGE1_BASE: r1_base_r     <= cfg_data;
        REG_RANGE1_END:  r1_end_r      <= cfg_data;
        REG_POLICY:      policy_r      <= cfg_data[0];
        REG_FRAME_COUNT: frame_count_r <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Request address and effective frame count.
  logic [ADDR_W-1:0] va_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              oor_r;
  logic              in_rng;
  logic [PAGE_W-1:0] va_page;

  assign va_page = va_r[ADDR_W-1:OFFSET_BITS];
  assign in_rng  = ((va_r >= r0_base_r) && (va_r < r0_end_r)) ||
                   ((va_r >= r1_base_r) && (va_r < r1_end_r));

  always_comb begin
    if (frame_count_r == '0) begin
      n_nxt = CNT_W'(1);
    end else if ({{(32-FC_W){1'b0}}, frame_count_r} > 32'(FRAMES)) begin
      n_nxt = CNT_W'(FRAMES);
    end else begin
      n_nxt = CNT_W'(frame_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r <= in_virtual_address;
    end
    if (cmd.check) begin
      n_r   <= n_nxt;
      oor_r <= !in_rng;
    end
  end

  // Frame tables and per-frame valid bits.
  logic [PAGE_W-1:0]  page_mem  [FRAMES];
  logic [STAMP_W-1:0] stamp_mem [FRAMES];
  logic [FRAMES-1:0]  frame_valid_r;
  logic [FRAME_W-1:0] fifo_next_r;
  logic [STAMP_W-1:0] clock_r;

  // Scan pipeline: issue a read, compare in the cycle after.
  logic [CNT_W-1:0]   issue_cnt_r;
  logic               issue;
  logic               rd_vld_r;
  logic [FRAME_W-1:0] rd_idx_r;
  logic [PAGE_W-1:0]  page_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               valid_q;

  assign issue = cmd.scan && (issue_cnt_r < n_r);

  logic [FRAME_W-1:0] wr_frame;
  logic               wr_page, wr_stamp;

  always_ff @(posedge clk) begin
    if (issue) begin
      page_q  <= page_mem[issue_cnt_r[FRAME_W-1:0]];
      stamp_q <= stamp_mem[issue_cnt_r[FRAME_W-1:0]];
      valid_q <= frame_valid_r[issue_cnt_r[FRAME_W-1:0]];
    end
    if (wr_page) begin
      page_mem[wr_frame] <= va_page;
    end
    if (wr_stamp) begin
      stamp_mem[wr_frame] <= clock_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.check) begin
        issue_cnt_r <= '0;
      end else if (issue) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= issue_cnt_r[FRAME_W-1:0];
    end
  end

  // Scan results.
  logic               hit_r, free_r;
  logic [FRAME_W-1:0] hit_idx_r, free_idx_r, lru_idx_r;
  logic [STAMP_W-1:0] best_r;
  logic [PAGE_W-1:0]  lru_page_r, fifo_page_r;
  logic [FRAME_W-1:0] fifo_eff;

  assign fifo_eff = ({1'b0, fifo_next_r} >= n_r) ? '0 : fifo_next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.check) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (valid_q && page_q == va_page && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!valid_q && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (valid_q && page_q == va_page && !hit_r) begin
        hit_idx_r <= rd_idx_r;
      end
      if (!valid_q && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (rd_idx_r == '0 || stamp_q < best_r) begin
        best_r     <= stamp_q;
        lru_idx_r  <= rd_idx_r;
        lru_page_r <= page_q;
      end
      if (rd_idx_r == fifo_eff) begin
        fifo_page_r <= page_q;
      end
    end
  end

  // Commit decision.
  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_evicted;
  logic [FRAME_W-1:0]  fifo_inc, fifo_nxt;
  logic                fifo_adv;

  assign fifo_inc = fifo_eff + FRAME_W'(1);

  always_comb begin
    wr_frame    = hit_idx_r;
    res_status  = STAT_HIT;
    res_evicted = '0;
    wr_page     = 1'b0;
    wr_stamp    = 1'b0;
    fifo_adv    = 1'b0;
    fifo_nxt    = (({1'b0, fifo_eff} + CNT_W'(1)) >= n_r) ? '0 : fifo_inc;
    if (oor_r) begin
      res_status = STAT_OOR;
    end else if (hit_r) begin
      wr_stamp = cmd.commit && (policy_r == POLICY_LRU);
    end else if (free_r) begin
      res_status = STAT_FILL;
      wr_frame   = free_idx_r;
      wr_page    = cmd.commit;
      wr_stamp   = cmd.commit;
    end else begin
      res_status = STAT_EVICT;
      wr_page    = cmd.commit;
      wr_stamp   = cmd.commit;
      if (policy_r == POLICY_LRU) begin
        wr_frame    = lru_idx_r;
        res_evicted = lru_page_r;
      end else begin
        wr_frame    = fifo_eff;
        res_evicted = fifo_page_r;
        fifo_adv    = cmd.commit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fifo_next_r   <= '0;
      clock_r       <= '0;
    end else begin
      if (wr_page) begin
        frame_valid_r[wr_frame] <= 1'b1;
      end
      if (fifo_adv) begin
        fifo_next_r <= fifo_nxt;
      end
      if (cmd.commit && !oor_r) begin
        clock_r <= clock_r + STAMP_W'(1);
      end
    end
  end

  // Output register.
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_pa_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_ev_r     <= res_evicted;
      if (oor_r) begin
        out_pa_r <= '0;
      end else begin
        out_pa_r <= {{(ADDR_W-FRAME_W-OFFSET_BITS){1'b0}}, wr_frame,
                     va_r[OFFSET_BITS-1:0]};
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_status           = out_status_r;
  assign out_evicted_page     = out_ev_r;

  assign sts.in_range  = in_rng;
  assign sts.scan_done = rd_vld_r && ({1'b0, rd_idx_r} == (n_r - CNT_W'(1)));
  assign sts.out_free  = !out_valid_r || out_ready;

  // A recorded hit always points at a resident frame.
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> frame_valid_r[hit_idx_r])
    else $error("hit recorded on a non-resident frame");

  // A commit always presents a result on the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit produced no result");

  // The access clock moves only on an in-range commit.
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && !oor_r) |=> $stable(clock_r))
    else $error("access clock moved without an in-range commit");

endmodule

### rtl/core/page_fault_frame_replacer.sv
// Channel  | Direction | Handshake              | Payload
// in       | input     | in_valid / in_ready    | in_virtual_address[31:0]
// out      | output    | out_valid / out_ready  | out_physical_address[31:0],
//          |           |                        | out_status[1:0], out_evicted_page[19:0]
// cfg      | input     | cfg_we (no wait)       | cfg_index[2:0], cfg_data[31:0]
//
// An in-range request goes from acceptance through the range check, the frame scan
// and the commit step; the scan covers the N frames of the effective frame count
// (1 to 64). An out-of-range request skips the scan. The scan reads one frame table
// entry per cycle.
// Reset (rst_n low, synchronous) clears the valid bits, FIFO pointer, access
// clock and configuration; no clearing pass is needed.
// A new request is accepted while a finished result waits in the output
// register; the next result waits in the commit step until that register drains.
module page_fault_frame_replacer
  import pffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     in_virtual_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_physical_address,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PAGE_W-1:0]     out_evicted_page
);

  // The controller sequences each request through range check, frame scan and
  // commit; the datapath holds the frame tables, the scan compare logic and
  // the output register.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  pffr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The scan gathers the first matching frame, the first free frame, the
  // oldest stamp and the page under the FIFO pointer in a single pass, so the
  // commit step can resolve hit, fill or eviction without a second read.
  pffr_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_physical_address (out_physical_address),
    .out_status           (out_status),
    .out_evicted_page     (out_evicted_page),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

### sim/testbench.sv
module testbench;
  import pffr_pkg::*;

  // One translated request as it leaves the block.
  typedef struct packed {
    logic [ADDR_W-1:0]   phys;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   evicted;
  } xlat_t;

  // The directed part is a table. A row either writes a register or sends one request.
  // Where the outcome is plain from the row itself, it is typed in and checked as written.
  // Otherwise the frame table model below supplies it.
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_ACCESS,
    ROW_ACCESS_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;  // ignored by request rows
    logic [CFG_DATA_W-1:0] value;     // register data, or the virtual address
    xlat_t                known;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 29;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 3;
  localparam int SEGMENTS      = 4;
  localparam int SEGMENT_REQS  = 58;

  // The comments on each row follow the frame table with three frames, then two, under FIFO.
  // The table switches to LRU later on.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // After reset both ranges are empty, so every address is rejected.
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_0000, '{32'h0, STAT_OOR, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'hFFFF_FFFF, '{32'h0, STAT_OOR, 20'h0}},
    '{ROW_WRITE, REG_RANGE0_BASE, 32'h0000_0000, '0},
    '{ROW_WRITE, REG_RANGE0_END,  32'h0001_0000, '0},
    '{ROW_WRITE, REG_RANGE1_BASE, 32'hFFFF_0000, '0},
    '{ROW_WRITE, REG_RANGE1_END,  32'hFFFF_FFFF, '0},
    '{ROW_WRITE, REG_FRAME_COUNT, 32'd3, '0},
    // Three free frames fill in order, with one hit in between.
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_0000, '{32'h0000_0000, STAT_FILL, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_0FFF, '{32'h0000_0FFF, STAT_HIT, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'hFFFF_FFFE, '{32'h0000_1FFE, STAT_FILL, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_A5A5, '{32'h0000_25A5, STAT_FILL, 20'h0}},
    // Both range ends are exclusive.
    '{ROW_ACCESS_KNOWN, '0, 32'hFFFF_FFFF, '{32'h0, STAT_OOR, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'h0001_0000, '{32'h0, STAT_OOR, 20'h0}},
    // The table is full, so FIFO evicts frame 0 and then frame 1 (the all-ones page).
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_1234, '{32'h0000_0234, STAT_EVICT, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'hFFFF_0000, '{32'h0000_1000, STAT_EVICT, 20'hFFFFF}},
    // Shrinking to two frames leaves the FIFO pointer at 2, so it must wrap to frame 0.
    '{ROW_WRITE, REG_FRAME_COUNT, 32'd2, '0},
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_2000, '{32'h0000_0000, STAT_EVICT, 20'h1}},
    // Under LRU the hit refreshes frame 1, so frame 0 goes next.
    '{ROW_WRITE, REG_POLICY, 32'(POLICY_LRU), '0},
    '{ROW_ACCESS_KNOWN, '0, 32'hFFFF_0ABC, '{32'h0000_1ABC, STAT_HIT, 20'h0}},
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_3000, '{32'h0000_0000, STAT_EVICT, 20'h2}},
    // A frame count of zero behaves as one.
    '{ROW_WRITE, REG_FRAME_COUNT, 32'd0, '0},
    '{ROW_ACCESS, '0, 32'h0000_3FFF, '0},
    '{ROW_ACCESS, '0, 32'h0000_0001, '0},
    // A count above the table size behaves as the full table.
    '{ROW_WRITE, REG_FRAME_COUNT, 32'h7F, '0},
    '{ROW_ACCESS, '0, 32'h0000_FFFF, '0},
    '{ROW_ACCESS, '0, 32'h0000_A000, '0},
    // A zero end disables the first range.
    '{ROW_WRITE, REG_RANGE0_END, 32'h0, '0},
    '{ROW_ACCESS_KNOWN, '0, 32'h0000_0000, '{32'h0, STAT_OOR, 20'h0}},
    '{ROW_ACCESS, '0, 32'hFFFF_5555, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     in_virtual_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     out_physical_address;
  logic [STATUS_W-1:0]   out_status;
  logic [PAGE_W-1:0]     out_evicted_page;

  page_fault_frame_replacer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_physical_address (out_physical_address),
    .out_status           (out_status),
    .out_evicted_page     (out_evicted_page)
  );

  always #5 clk = ~clk;

  // The model's copy of the registers and of the frame table.
  logic [ADDR_W-1:0]  range0_lo, range0_hi, range1_lo, range1_hi;
  logic               lru_mode;
  logic [FC_W-1:0]    frames_setting;
  logic [PAGE_W-1:0]  resident_page [FRAMES];
  logic               resident_valid [FRAMES];
  logic [STAMP_W-1:0] last_use [FRAMES];
  int unsigned        fifo_victim;
  logic [STAMP_W-1:0] use_clock;

  xlat_t pending_xlats [$];
  xlat_t head_xlat;
  int    mismatches = 0;
  int    cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  // Work out the result of one accepted request and advance the frame table.
  function automatic xlat_t translate(input logic [ADDR_W-1:0] va);
    xlat_t             res;
    int unsigned       n;
    int                slot;
    logic [PAGE_W-1:0] page;
    logic              in_window;
    res  = '0;
    n    = (frames_setting == 0) ? 1 : ((frames_setting > FRAMES) ? FRAMES : frames_setting);
    page = va[ADDR_W-1:OFFSET_BITS];
    in_window = (va >= range0_lo && va < range0_hi) || (va >= range1_lo && va < range1_hi);
    if (!in_window) begin
      // Rejected addresses leave the table and the use clock alone.
      res.status = STAT_OOR;
    end else begin
      slot = -1;
      for (int i = 0; i < n; i++) begin
        if (slot < 0 && resident_valid[i] && resident_page[i] == page) slot = i;
      end
      if (slot >= 0) begin
        res.status = STAT_HIT;
        if (lru_mode == POLICY_LRU) last_use[slot] = use_clock;
      end else begin
        for (int i = 0; i < n; i++) begin
          if (slot < 0 && !resident_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          res.status = STAT_FILL;
        end else begin
          res.status = STAT_EVICT;
          if (lru_mode == POLICY_LRU) begin
            // The oldest stamp loses; on a tie the lowest frame is the one evicted.
            slot = 0;
            for (int i = 1; i < n; i++) begin
              if (last_use[i] < last_use[slot]) slot = i;
            end
          end else begin
            if (fifo_victim >= n) fifo_victim = 0;
            slot = fifo_victim;
            fifo_victim = (fifo_victim + 1 >= n) ? 0 : fifo_victim + 1;
          end
          res.evicted = resident_page[slot];
        end
        resident_page[slot]  = page;
        resident_valid[slot] = 1'b1;
        last_use[slot]       = use_clock;
      end
      use_clock = use_clock + 1;
      res.phys  = (ADDR_W'(slot) << OFFSET_BITS) | ADDR_W'(va[OFFSET_BITS-1:0]);
    end
    return res;
  endfunction

  // Offer one request, with a random idle gap first, and file its expected result once accepted.
  // Valid is left high after acceptance, so a back-to-back request only changes the address.
  task automatic send_request(input logic [ADDR_W-1:0] va, input logic use_known,
                              input xlat_t known);
    xlat_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_virtual_address <= va;
    do @(posedge clk); while (!in_ready);
    predicted = translate(va);
    pending_xlats.push_back(use_known ? known : predicted);
  endtask

  // Drop valid and wait until every expected result has been taken, plus a short pause.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_xlats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A register write takes effect at the edge where cfg_we is high. The model follows at once.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RANGE0_BASE: range0_lo = val;
      REG_RANGE0_END:  range0_hi = val;
      REG_RANGE1_BASE: range1_lo = val;
      REG_RANGE1_END:  range1_hi = val;
      REG_POLICY:      lru_mode = val[0];
      REG_FRAME_COUNT: frames_setting = val[FC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls at random. Outputs are sampled as they stood just before the edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_xlats.size() == 0) begin
        $error("unexpected result: physical_address %h status %0d evicted_page %h",
               out_physical_address, out_status, out_evicted_page);
        mismatches++;
      end else begin
        head_xlat = pending_xlats.pop_front();
        if (out_physical_address !== head_xlat.phys) begin
          $error("physical_address: expected %h, got %h", head_xlat.phys, out_physical_address);
          mismatches++;
        end
        if (out_status !== head_xlat.status) begin
          $error("status: expected %0d, got %0d", head_xlat.status, out_status);
          mismatches++;
        end
        if (out_evicted_page !== head_xlat.evicted) begin
          $error("evicted_page: expected %h, got %h", head_xlat.evicted, out_evicted_page);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int unsigned       n_eff;
    int                seg;
    logic [ADDR_W-1:0] span0, span1, lo, hi, va;
    logic [FC_W-1:0]   count_pick;

    // Reset state of the model: empty table, zero clock and pointer, register defaults.
    range0_lo = '0; range0_hi = '0; range1_lo = '0; range1_hi = '0;
    lru_mode = POLICY_FIFO;
    frames_setting = FC_W'(FRAMES);
    for (int i = 0; i < FRAMES; i++) begin
      resident_page[i]  = '0;
      resident_valid[i] = 1'b0;
      last_use[i]       = '0;
    end
    fifo_victim = 0;
    use_clock   = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The directed table runs with the first idling profile.
    send_idle_pct = 27;
    recv_idle_pct = 45;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle();
        cfg_write(directed_rows[r].reg_index, directed_rows[r].value);
      end else begin
        send_request(directed_rows[r].value, directed_rows[r].kind == ROW_ACCESS_KNOWN,
                     directed_rows[r].known);
      end
    end

    // Random part: each phase has its own idling profile and several register settings.
    // Most requests hit a small window of pages around the range bases, up to four pages
    // more than the table has frames, so hits, fills and evictions all stay frequent.
    // The rest are range edges and raw 32-bit noise.
    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : ((phase == 1) ? 45 : 0);
      recv_idle_pct = (phase == 0) ? 45 : ((phase == 1) ? 27 : 0);
      for (int s = 0; s < SEGMENTS; s++) begin
        seg = phase * SEGMENTS + s;
        case ($urandom_range(9))
          0:       count_pick = '0;
          1:       count_pick = FC_W'(1);
          2:       count_pick = FC_W'(FRAMES);
          3:       count_pick = '1;
          default: count_pick = FC_W'($urandom_range(12, 2));
        endcase
        n_eff = (count_pick == 0) ? 1 : ((count_pick > FRAMES) ? FRAMES : count_pick);
        span0 = ADDR_W'(n_eff + $urandom_range(4)) << OFFSET_BITS;
        span1 = ADDR_W'(n_eff + $urandom_range(4)) << OFFSET_BITS;
        settle();
        cfg_write(REG_POLICY, $urandom_range(1) ? 32'(POLICY_LRU) : 32'(POLICY_FIFO));
        cfg_write(REG_FRAME_COUNT, 32'(count_pick));
        lo = $urandom;
        if ($urandom_range(1)) lo[OFFSET_BITS-1:0] = '0;
        if (seg == 1) begin
          // Full address space, the widest first range there is.
          cfg_write(REG_RANGE0_BASE, '0);
          cfg_write(REG_RANGE0_END, '1);
        end else begin
          cfg_write(REG_RANGE0_BASE, lo);
          cfg_write(REG_RANGE0_END, lo + span0);
        end
        lo = $urandom;
        if ($urandom_range(1)) lo[OFFSET_BITS-1:0] = '0;
        if (seg == 6) begin
          // Second range pressed against the top of the address space.
          cfg_write(REG_RANGE1_BASE, ~span1);
          cfg_write(REG_RANGE1_END, '1);
        end else begin
          cfg_write(REG_RANGE1_BASE, lo);
          cfg_write(REG_RANGE1_END, ($urandom_range(3) == 0) ? '0 : lo + span1);
        end
        for (int k = 0; k < SEGMENT_REQS; k++) begin
          case ($urandom_range(9))
            0: va = $urandom;
            1: begin
              lo = $urandom_range(1) ? range1_lo : range0_lo;
              hi = (lo == range1_lo) ? range1_hi : range0_hi;
              case ($urandom_range(3))
                0:       va = lo - 1;
                1:       va = lo;
                2:       va = hi - 1;
                default: va = hi;
              endcase
            end
            default: begin
              if ($urandom_range(1) && range1_hi != 0)
                va = range1_lo + ADDR_W'($urandom_range(span1 - 1));
              else
                va = range0_lo + ADDR_W'($urandom_range(span0 - 1));
            end
          endcase
          send_request(va, 1'b0, '0);
        end
      end
    end

    // Let every outstanding result drain, then leave room for any stray one.
    settle();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
